/* hdl/omep_pkg.sv */
// omep_pkg: shared types, codes and the field width table of the
// object metadata element parser. No dependencies.
`timescale 1ns / 1ps

package omep_pkg;

   // request operation codes
   localparam logic [1:0] OP_MAP = 2'd0;
   localparam logic [1:0] OP_BIT = 2'd1;
   localparam logic [1:0] OP_END = 2'd2;

   // configuration register indexes
   localparam logic [7:0] CSR_OBJECT_COUNT   = 8'd0;
   localparam logic [7:0] CSR_PRESENCE_ORDER = 8'd1;

   // final status codes
   localparam logic [2:0] ST_PASS      = 3'd0;
   localparam logic [2:0] ST_UNSUP     = 3'd1;
   localparam logic [2:0] ST_TRUNC     = 3'd2;
   localparam logic [2:0] ST_OVERRUN   = 3'd3;
   localparam logic [2:0] ST_PADDING   = 3'd4;
   localparam logic [2:0] ST_BAD_CFG   = 3'd5;

   // syntax field codes, also the parse state
   localparam logic [5:0] F_SO_CODE       = 6'd0;
   localparam logic [5:0] F_SO_INDEX      = 6'd1;
   localparam logic [5:0] F_SO_BITS       = 6'd2;
   localparam logic [5:0] F_BLK_COUNT     = 6'd3;
   localparam logic [5:0] F_BLK_OFFSET    = 6'd4;
   localparam logic [5:0] F_RAMP_CODE     = 6'd5;
   localparam logic [5:0] F_RAMP_SEL      = 6'd6;
   localparam logic [5:0] F_RAMP_INDEX    = 6'd7;
   localparam logic [5:0] F_RAMP_BITS     = 6'd8;
   localparam logic [5:0] F_RES_FLAG      = 6'd9;
   localparam logic [5:0] F_RES_DATA      = 6'd10;
   localparam logic [5:0] F_NOT_ACTIVE    = 6'd11;
   localparam logic [5:0] F_BASIC_STATUS  = 6'd12;
   localparam logic [5:0] F_BASIC_PRES    = 6'd13;
   localparam logic [5:0] F_GAIN_INDEX    = 6'd14;
   localparam logic [5:0] F_GAIN_BITS     = 6'd15;
   localparam logic [5:0] F_DEF_PRIO      = 6'd16;
   localparam logic [5:0] F_PRIO_BITS     = 6'd17;
   localparam logic [5:0] F_RENDER_STATUS = 6'd18;
   localparam logic [5:0] F_RENDER_PRES   = 6'd19;
   localparam logic [5:0] F_DIFF_FLAG     = 6'd20;
   localparam logic [5:0] F_DIFF_X        = 6'd21;
   localparam logic [5:0] F_DIFF_Y        = 6'd22;
   localparam logic [5:0] F_DIFF_Z        = 6'd23;
   localparam logic [5:0] F_ABS_X         = 6'd24;
   localparam logic [5:0] F_ABS_Y         = 6'd25;
   localparam logic [5:0] F_ABS_ZS        = 6'd26;
   localparam logic [5:0] F_ABS_Z         = 6'd27;
   localparam logic [5:0] F_DIST_FLAG     = 6'd28;
   localparam logic [5:0] F_INF_FLAG      = 6'd29;
   localparam logic [5:0] F_DIST_INDEX    = 6'd30;
   localparam logic [5:0] F_ZONE          = 6'd31;
   localparam logic [5:0] F_ELEV          = 6'd32;
   localparam logic [5:0] F_SIZE_INDEX    = 6'd33;
   localparam logic [5:0] F_SIZE_SCALAR   = 6'd34;
   localparam logic [5:0] F_SIZE_W        = 6'd35;
   localparam logic [5:0] F_SIZE_D        = 6'd36;
   localparam logic [5:0] F_SIZE_H        = 6'd37;
   localparam logic [5:0] F_SCREEN_FLAG   = 6'd38;
   localparam logic [5:0] F_SCREEN_FACTOR = 6'd39;
   localparam logic [5:0] F_DEPTH_FACTOR  = 6'd40;
   localparam logic [5:0] F_SNAP          = 6'd41;
   localparam logic [5:0] F_ADD_FLAG      = 6'd42;
   localparam logic [5:0] F_ADD_SIZE      = 6'd43;
   localparam logic [5:0] F_ADD_BYTE      = 6'd44;
   localparam logic [5:0] F_PAD           = 6'd45;

   // bed map write request
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic       flag;
   } bed_wr_type;

   // one result record
   typedef struct packed {
      logic        kind;
      logic [5:0]  field_id;
      logic [10:0] field_value;
      logic [7:0]  object_index;
      logic [2:0]  block_index;
      logic [2:0]  status;
      logic [16:0] bits_consumed;
      logic [16:0] padding_bits;
      logic        last;
   } rsp_type;

   // bit width of each syntax field
   function automatic logic [3:0] width_of(input logic [5:0] id);
      logic [3:0] w;
      case (id)
         F_SO_CODE:       w = 4'd2;
         F_SO_INDEX:      w = 4'd2;
         F_SO_BITS:       w = 4'd5;
         F_BLK_COUNT:     w = 4'd3;
         F_BLK_OFFSET:    w = 4'd6;
         F_RAMP_CODE:     w = 4'd2;
         F_RAMP_SEL:      w = 4'd1;
         F_RAMP_INDEX:    w = 4'd4;
         F_RAMP_BITS:     w = 4'd11;
         F_RES_FLAG:      w = 4'd1;
         F_RES_DATA:      w = 4'd5;
         F_NOT_ACTIVE:    w = 4'd1;
         F_BASIC_STATUS:  w = 4'd2;
         F_BASIC_PRES:    w = 4'd2;
         F_GAIN_INDEX:    w = 4'd2;
         F_GAIN_BITS:     w = 4'd6;
         F_DEF_PRIO:      w = 4'd1;
         F_PRIO_BITS:     w = 4'd5;
         F_RENDER_STATUS: w = 4'd2;
         F_RENDER_PRES:   w = 4'd4;
         F_DIFF_FLAG:     w = 4'd1;
         F_DIFF_X:        w = 4'd3;
         F_DIFF_Y:        w = 4'd3;
         F_DIFF_Z:        w = 4'd3;
         F_ABS_X:         w = 4'd6;
         F_ABS_Y:         w = 4'd6;
         F_ABS_ZS:        w = 4'd1;
         F_ABS_Z:         w = 4'd4;
         F_DIST_FLAG:     w = 4'd1;
         F_INF_FLAG:      w = 4'd1;
         F_DIST_INDEX:    w = 4'd4;
         F_ZONE:          w = 4'd3;
         F_ELEV:          w = 4'd1;
         F_SIZE_INDEX:    w = 4'd2;
         F_SIZE_SCALAR:   w = 4'd5;
         F_SIZE_W:        w = 4'd5;
         F_SIZE_D:        w = 4'd5;
         F_SIZE_H:        w = 4'd5;
         F_SCREEN_FLAG:   w = 4'd1;
         F_SCREEN_FACTOR: w = 4'd3;
         F_DEPTH_FACTOR:  w = 4'd2;
         F_SNAP:          w = 4'd1;
         F_ADD_FLAG:      w = 4'd1;
         F_ADD_SIZE:      w = 4'd4;
         F_ADD_BYTE:      w = 4'd8;
         default:         w = 4'd1;
      endcase
      return w;
   endfunction

endpackage

/* hdl/omep_ifs.sv */
// omep_ifs: request, response and register write channel interfaces.
// Depends on nothing.
`timescale 1ns / 1ps

interface omep_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       body_bit;
   logic [7:0] map_object;
   logic       map_flag;
   modport source (output valid, op, body_bit, map_object, map_flag, input ready);
   modport sink (input valid, op, body_bit, map_object, map_flag, output ready);
endinterface

interface omep_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [5:0]  field_id;
   logic [10:0] field_value;
   logic [7:0]  object_index;
   logic [2:0]  block_index;
   logic [2:0]  status;
   logic [16:0] bits_consumed;
   logic [16:0] padding_bits;
   logic        last;
   modport source (output valid, kind, field_id, field_value, object_index, block_index,
                   status, bits_consumed, padding_bits, last, input ready);
   modport sink (input valid, kind, field_id, field_value, object_index, block_index,
                 status, bits_consumed, padding_bits, last, output ready);
endinterface

interface omep_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hdl/omep_bed_map.sv */
// omep_bed_map: per-object bed/ISF flag memory with a registered read port.
// Depends on omep_pkg.
`timescale 1ns / 1ps

module omep_bed_map #(
   parameter int MAX_OBJECTS = 159
) (
   input  logic               clock,
   input  omep_pkg::bed_wr_type wr,
   input  logic [7:0]         rd_addr,
   output logic               rd_flag
);
   localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

   logic mem [MAX_OBJECTS];
   logic rd_ff;
   logic wr_ok;
   logic rd_ok;

   assign wr_ok = wr.en && ({1'b0, wr.addr} < 9'(MAX_OBJECTS));
   assign rd_ok = {1'b0, rd_addr} < 9'(MAX_OBJECTS);

   // write port
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr.addr[IW-1:0]] <= wr.flag;
      end
   end

   // read port, forwards a write to the same entry
   always_ff @(posedge clock) begin
      if (wr_ok && wr.addr == rd_addr) begin
         rd_ff <= wr.flag;
      end else if (rd_ok) begin
         rd_ff <= mem[rd_addr[IW-1:0]];
      end else begin
         rd_ff <= 1'b0;
      end
   end

   assign rd_flag = rd_ff;
endmodule

/* hdl/omep_parser.sv */
// omep_parser: configuration registers and the bit-serial syntax walker.
// Depends on omep_pkg.
`timescale 1ns / 1ps

module omep_parser #(
   parameter int MAX_OBJECTS   = 159,
   parameter int MAX_BLOCKS    = 8,
   parameter int MAX_BODY_BITS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_acc,
   input  logic [1:0]           op,
   input  logic                 body_bit,
   input  logic [7:0]           map_object,
   input  logic                 map_flag,
   input  logic                 csr_we,
   input  logic [7:0]           csr_index,
   input  logic [7:0]           csr_data,
   input  logic                 bed_flag,
   output omep_pkg::bed_wr_type bed_wr,
   output logic [7:0]           bed_rd_addr,
   output logic                 res_valid,
   output omep_pkg::rsp_type    res
);
   localparam int BPW = $clog2(MAX_BODY_BITS + 1);

   typedef struct packed {
      logic [5:0] id;
      logic [5:0] pres;
   } step_type;

   logic [7:0]     obj_count_ff;
   logic           order_ff;
   logic [5:0]     state_ff, state_in;
   logic [10:0]    shift_ff, shift_in;
   logic [3:0]     left_ff, left_in;
   logic [7:0]     obj_ff, obj_in;
   logic [2:0]     blk_ff, blk_in;
   logic [3:0]     btot_ff, btot_in;
   logic [5:0]     pres_ff, pres_in;
   logic           cond_ff, cond_in;
   logic [4:0]     xleft_ff, xleft_in;
   logic [BPW-1:0] bpos_ff, bpos_in;
   logic [BPW-1:0] pcnt_ff, pcnt_in;
   logic [2:0]     err_ff, err_in;
   logic           uns_ff, uns_in;

   // render info entry chain
   function automatic logic [5:0] f_screen(input logic [5:0] p);
      return p[5] ? omep_pkg::F_SCREEN_FLAG : omep_pkg::F_SNAP;
   endfunction
   function automatic logic [5:0] f_size(input logic [5:0] p);
      return p[4] ? omep_pkg::F_SIZE_INDEX : f_screen(p);
   endfunction
   function automatic logic [5:0] f_zone(input logic [5:0] p);
      return p[3] ? omep_pkg::F_ZONE : f_size(p);
   endfunction
   function automatic logic [5:0] f_pos(input logic [5:0] p, input logic [2:0] b);
      if (p[2]) begin
         return (b == 3'd0) ? omep_pkg::F_ABS_X : omep_pkg::F_DIFF_FLAG;
      end
      return f_zone(p);
   endfunction

   // basic info exit chain
   function automatic step_type f_after(input logic [5:0] p, input logic c,
                                        input logic bd, input logic [2:0] b);
      step_type s;
      s.pres = p;
      if (c || bd) begin
         s.id = omep_pkg::F_ADD_FLAG;
      end else if (b == 3'd0) begin
         s.pres = p | 6'h3C;
         s.id = f_pos(s.pres, b);
      end else begin
         s.id = omep_pkg::F_RENDER_STATUS;
      end
      return s;
   endfunction
   function automatic step_type f_p0(input logic [5:0] p, input logic c,
                                     input logic bd, input logic [2:0] b);
      step_type s;
      s.id = omep_pkg::F_DEF_PRIO;
      s.pres = p;
      if (!p[0]) begin
         s = f_after(p, c, bd, b);
      end
      return s;
   endfunction
   function automatic step_type f_body(input logic [5:0] p, input logic c,
                                       input logic bd, input logic [2:0] b);
      step_type s;
      s.id = omep_pkg::F_GAIN_INDEX;
      s.pres = p;
      if (!p[1]) begin
         s = f_p0(p, c, bd, b);
      end
      return s;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         obj_count_ff <= 8'd1;
         order_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == omep_pkg::CSR_OBJECT_COUNT) begin
            obj_count_ff <= csr_data;
         end else if (csr_index == omep_pkg::CSR_PRESENCE_ORDER) begin
            order_ff <= csr_data[0];
         end
      end
   end

   // bed map load path
   always_comb begin
      bed_wr.en = req_acc && op == omep_pkg::OP_MAP;
      bed_wr.addr = map_object;
      bed_wr.flag = map_flag;
   end

   // next parse state and result record
   always_comb begin
      logic        do_go;
      logic [5:0]  go_id;
      logic        do_bud;
      logic        do_obd;
      logic        do_enter;
      logic [10:0] v;
      logic [2:0]  blk_n;
      logic        bad;
      logic [2:0]  st;
      step_type    s;

      state_in = state_ff;
      shift_in = shift_ff;
      left_in = left_ff;
      obj_in = obj_ff;
      blk_in = blk_ff;
      btot_in = btot_ff;
      pres_in = pres_ff;
      cond_in = cond_ff;
      xleft_in = xleft_ff;
      bpos_in = bpos_ff;
      pcnt_in = pcnt_ff;
      err_in = err_ff;
      uns_in = uns_ff;
      do_go = 1'b0;
      go_id = state_ff;
      do_bud = 1'b0;
      do_obd = 1'b0;
      do_enter = 1'b0;
      v = '0;
      blk_n = blk_ff + 3'd1;
      bad = (obj_count_ff == 8'd0) || ({1'b0, obj_count_ff} > 9'(MAX_OBJECTS));
      st = omep_pkg::ST_PASS;
      s = '0;
      res_valid = 1'b0;
      res = '0;

      if (req_acc && op == omep_pkg::OP_BIT && bpos_ff < BPW'(MAX_BODY_BITS)) begin
         bpos_in = bpos_ff + BPW'(1);
         if (err_ff != omep_pkg::ST_PASS) begin
            // bits after an error are only counted
         end else if (state_ff == omep_pkg::F_PAD) begin
            pcnt_in = pcnt_ff + BPW'(1);
            if (body_bit) begin
               err_in = omep_pkg::ST_PADDING;
            end
         end else begin
            shift_in = {shift_ff[9:0], body_bit};
            left_in = (left_ff != 4'd0) ? left_ff - 4'd1 : 4'd0;
            if (left_in == 4'd0) begin
               v = shift_in;
               if (state_ff == omep_pkg::F_RENDER_PRES && !order_ff) begin
                  v = {7'd0, shift_in[0], shift_in[1], shift_in[2], shift_in[3]};
               end
               res_valid = 1'b1;
               res.field_id = state_ff;
               res.field_value = v;
               res.object_index = obj_ff;
               res.block_index = blk_ff;
               do_go = 1'b1;
               case (state_ff)
                  omep_pkg::F_SO_CODE: begin
                     if (v == 11'd1) begin
                        go_id = omep_pkg::F_SO_INDEX;
                     end else if (v == 11'd2) begin
                        go_id = omep_pkg::F_SO_BITS;
                     end else begin
                        if (v == 11'd3) uns_in = 1'b1;
                        go_id = omep_pkg::F_BLK_COUNT;
                     end
                  end
                  omep_pkg::F_SO_INDEX, omep_pkg::F_SO_BITS: go_id = omep_pkg::F_BLK_COUNT;
                  omep_pkg::F_BLK_COUNT: begin
                     btot_in = {1'b0, v[2:0]} + 4'd1;
                     if (btot_in > 4'(MAX_BLOCKS)) begin
                        err_in = omep_pkg::ST_BAD_CFG;
                        do_go = 1'b0;
                     end else begin
                        blk_in = 3'd0;
                        go_id = omep_pkg::F_BLK_OFFSET;
                     end
                  end
                  omep_pkg::F_BLK_OFFSET: go_id = omep_pkg::F_RAMP_CODE;
                  omep_pkg::F_RAMP_CODE: begin
                     if (v == 11'd3) go_id = omep_pkg::F_RAMP_SEL;
                     else do_bud = 1'b1;
                  end
                  omep_pkg::F_RAMP_SEL: begin
                     go_id = (v != 11'd0) ? omep_pkg::F_RAMP_INDEX : omep_pkg::F_RAMP_BITS;
                  end
                  omep_pkg::F_RAMP_INDEX, omep_pkg::F_RAMP_BITS: do_bud = 1'b1;
                  omep_pkg::F_RES_FLAG: begin
                     if (v == 11'd0) go_id = omep_pkg::F_RES_DATA;
                     else do_enter = 1'b1;
                  end
                  omep_pkg::F_RES_DATA: do_enter = 1'b1;
                  omep_pkg::F_NOT_ACTIVE: begin
                     cond_in = v[0];
                     pres_in = 6'd0;
                     if (v != 11'd0) begin
                        s = f_after(6'd0, v[0], bed_flag, blk_ff);
                        go_id = s.id;
                        pres_in = s.pres;
                     end else if (blk_ff == 3'd0) begin
                        s = f_body(6'd3, 1'b0, bed_flag, blk_ff);
                        go_id = s.id;
                        pres_in = s.pres;
                     end else begin
                        go_id = omep_pkg::F_BASIC_STATUS;
                     end
                  end
                  omep_pkg::F_BASIC_STATUS: begin
                     if (v == 11'd1) begin
                        s = f_body(6'd3, cond_ff, bed_flag, blk_ff);
                        go_id = s.id;
                        pres_in = s.pres;
                     end else if (v == 11'd3) begin
                        go_id = omep_pkg::F_BASIC_PRES;
                     end else begin
                        s = f_after(pres_ff, cond_ff, bed_flag, blk_ff);
                        go_id = s.id;
                        pres_in = s.pres;
                     end
                  end
                  omep_pkg::F_BASIC_PRES: begin
                     s = f_body({4'd0, v[1:0]}, cond_ff, bed_flag, blk_ff);
                     go_id = s.id;
                     pres_in = s.pres;
                  end
                  omep_pkg::F_GAIN_INDEX: begin
                     if (v == 11'd2) begin
                        go_id = omep_pkg::F_GAIN_BITS;
                     end else begin
                        s = f_p0(pres_ff, cond_ff, bed_flag, blk_ff);
                        go_id = s.id;
                        pres_in = s.pres;
                     end
                  end
                  omep_pkg::F_GAIN_BITS: begin
                     s = f_p0(pres_ff, cond_ff, bed_flag, blk_ff);
                     go_id = s.id;
                     pres_in = s.pres;
                  end
                  omep_pkg::F_DEF_PRIO: begin
                     if (v == 11'd0) begin
                        go_id = omep_pkg::F_PRIO_BITS;
                     end else begin
                        s = f_after(pres_ff, cond_ff, bed_flag, blk_ff);
                        go_id = s.id;
                        pres_in = s.pres;
                     end
                  end
                  omep_pkg::F_PRIO_BITS: begin
                     s = f_after(pres_ff, cond_ff, bed_flag, blk_ff);
                     go_id = s.id;
                     pres_in = s.pres;
                  end
                  omep_pkg::F_RENDER_STATUS: begin
                     if (v == 11'd1) begin
                        pres_in = pres_ff | 6'h3C;
                        go_id = f_pos(pres_in, blk_ff);
                     end else if (v == 11'd3) begin
                        go_id = omep_pkg::F_RENDER_PRES;
                     end else begin
                        go_id = omep_pkg::F_ADD_FLAG;
                     end
                  end
                  omep_pkg::F_RENDER_PRES: begin
                     pres_in = {v[3:0], pres_ff[1:0]};
                     go_id = f_pos(pres_in, blk_ff);
                  end
                  omep_pkg::F_DIFF_FLAG: begin
                     go_id = (v != 11'd0) ? omep_pkg::F_DIFF_X : omep_pkg::F_ABS_X;
                  end
                  omep_pkg::F_DIFF_X: go_id = omep_pkg::F_DIFF_Y;
                  omep_pkg::F_DIFF_Y: go_id = omep_pkg::F_DIFF_Z;
                  omep_pkg::F_DIFF_Z: go_id = omep_pkg::F_DIST_FLAG;
                  omep_pkg::F_ABS_X: go_id = omep_pkg::F_ABS_Y;
                  omep_pkg::F_ABS_Y: go_id = omep_pkg::F_ABS_ZS;
                  omep_pkg::F_ABS_ZS: go_id = omep_pkg::F_ABS_Z;
                  omep_pkg::F_ABS_Z: go_id = omep_pkg::F_DIST_FLAG;
                  omep_pkg::F_DIST_FLAG: begin
                     go_id = (v != 11'd0) ? omep_pkg::F_INF_FLAG : f_zone(pres_ff);
                  end
                  omep_pkg::F_INF_FLAG: begin
                     go_id = (v == 11'd0) ? omep_pkg::F_DIST_INDEX : f_zone(pres_ff);
                  end
                  omep_pkg::F_DIST_INDEX: go_id = f_zone(pres_ff);
                  omep_pkg::F_ZONE: go_id = omep_pkg::F_ELEV;
                  omep_pkg::F_ELEV: go_id = f_size(pres_ff);
                  omep_pkg::F_SIZE_INDEX: begin
                     if (v == 11'd1) go_id = omep_pkg::F_SIZE_SCALAR;
                     else if (v == 11'd2) go_id = omep_pkg::F_SIZE_W;
                     else go_id = f_screen(pres_ff);
                  end
                  omep_pkg::F_SIZE_SCALAR: go_id = f_screen(pres_ff);
                  omep_pkg::F_SIZE_W: go_id = omep_pkg::F_SIZE_D;
                  omep_pkg::F_SIZE_D: go_id = omep_pkg::F_SIZE_H;
                  omep_pkg::F_SIZE_H: go_id = f_screen(pres_ff);
                  omep_pkg::F_SCREEN_FLAG: begin
                     go_id = (v != 11'd0) ? omep_pkg::F_SCREEN_FACTOR : omep_pkg::F_SNAP;
                  end
                  omep_pkg::F_SCREEN_FACTOR: go_id = omep_pkg::F_DEPTH_FACTOR;
                  omep_pkg::F_DEPTH_FACTOR: go_id = omep_pkg::F_SNAP;
                  omep_pkg::F_SNAP: go_id = omep_pkg::F_ADD_FLAG;
                  omep_pkg::F_ADD_FLAG: begin
                     if (v != 11'd0) go_id = omep_pkg::F_ADD_SIZE;
                     else do_obd = 1'b1;
                  end
                  omep_pkg::F_ADD_SIZE: begin
                     xleft_in = {1'b0, v[3:0]} + 5'd1;
                     go_id = omep_pkg::F_ADD_BYTE;
                  end
                  omep_pkg::F_ADD_BYTE: begin
                     xleft_in = (xleft_ff != 5'd0) ? xleft_ff - 5'd1 : 5'd0;
                     if (xleft_in == 5'd0) do_obd = 1'b1;
                     else go_id = omep_pkg::F_ADD_BYTE;
                  end
                  default: go_id = omep_pkg::F_PAD;
               endcase

               // end of one block update
               if (do_bud) begin
                  if ({1'b0, blk_n} >= btot_ff || blk_n == 3'd0) begin
                     blk_in = 3'd0;
                     go_id = omep_pkg::F_RES_FLAG;
                  end else begin
                     blk_in = blk_n;
                     go_id = omep_pkg::F_BLK_OFFSET;
                  end
               end

               // start of the object loop
               if (do_enter) begin
                  if (bad) begin
                     err_in = omep_pkg::ST_BAD_CFG;
                     do_go = 1'b0;
                  end else begin
                     obj_in = 8'd0;
                     blk_in = 3'd0;
                     go_id = omep_pkg::F_NOT_ACTIVE;
                  end
               end

               // end of one object info block
               if (do_obd) begin
                  go_id = omep_pkg::F_NOT_ACTIVE;
                  if ({1'b0, blk_n} >= btot_ff || blk_n == 3'd0) begin
                     blk_in = 3'd0;
                     if ({1'b0, obj_ff} + 9'd1 >= {1'b0, obj_count_ff}) begin
                        go_id = omep_pkg::F_PAD;
                     end else begin
                        obj_in = obj_ff + 8'd1;
                     end
                  end else begin
                     blk_in = blk_n;
                  end
               end
            end
         end
      end else if (req_acc && op == omep_pkg::OP_END) begin
         if (bpos_ff == '0) st = omep_pkg::ST_TRUNC;
         else if (bad) st = omep_pkg::ST_BAD_CFG;
         else if (err_ff != omep_pkg::ST_PASS) st = err_ff;
         else if (state_ff == omep_pkg::F_ADD_BYTE) st = omep_pkg::ST_OVERRUN;
         else if (state_ff != omep_pkg::F_PAD) st = omep_pkg::ST_TRUNC;
         else if (uns_ff) st = omep_pkg::ST_UNSUP;
         else st = omep_pkg::ST_PASS;
         res_valid = 1'b1;
         res.kind = 1'b1;
         res.field_id = state_ff;
         res.object_index = obj_ff;
         res.block_index = blk_ff;
         res.status = st;
         res.bits_consumed = (st == omep_pkg::ST_PASS) ? 17'(bpos_ff) : 17'd0;
         res.padding_bits = (st == omep_pkg::ST_PASS) ? 17'(pcnt_ff) : 17'd0;
         res.last = 1'b1;
         // back to the start of a new element
         do_go = 1'b1;
         go_id = omep_pkg::F_SO_CODE;
         obj_in = 8'd0;
         blk_in = 3'd0;
         btot_in = 4'd0;
         pres_in = 6'd0;
         cond_in = 1'b0;
         xleft_in = 5'd0;
         bpos_in = '0;
         pcnt_in = '0;
         err_in = omep_pkg::ST_PASS;
         uns_in = 1'b0;
      end

      if (do_go) begin
         state_in = go_id;
         shift_in = 11'd0;
         left_in = omep_pkg::width_of(go_id);
      end
   end

   assign bed_rd_addr = obj_in;

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= omep_pkg::F_SO_CODE;
         shift_ff <= 11'd0;
         left_ff <= omep_pkg::width_of(omep_pkg::F_SO_CODE);
         obj_ff <= 8'd0;
         blk_ff <= 3'd0;
         btot_ff <= 4'd0;
         pres_ff <= 6'd0;
         cond_ff <= 1'b0;
         xleft_ff <= 5'd0;
         bpos_ff <= '0;
         pcnt_ff <= '0;
         err_ff <= omep_pkg::ST_PASS;
         uns_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         shift_ff <= shift_in;
         left_ff <= left_in;
         obj_ff <= obj_in;
         blk_ff <= blk_in;
         btot_ff <= btot_in;
         pres_ff <= pres_in;
         cond_ff <= cond_in;
         xleft_ff <= xleft_in;
         bpos_ff <= bpos_in;
         pcnt_ff <= pcnt_in;
         err_ff <= err_in;
         uns_ff <= uns_in;
      end
   end
endmodule

/* hdl/omep_out_buf.sv */
// omep_out_buf: result register plus skid stage driving the response channel.
// Depends on omep_pkg and omep_rsp_if.
`timescale 1ns / 1ps

module omep_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  omep_pkg::rsp_type in_data,
   output logic              in_ready,
   omep_rsp_if.source        rsp
);
   logic              out_v_ff;
   logic              skid_v_ff;
   omep_pkg::rsp_type out_ff;
   omep_pkg::rsp_type skid_ff;
   logic              pop;

   assign pop = out_v_ff && rsp.ready;
   assign in_ready = !skid_v_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || pop) begin
         out_v_ff <= skid_v_ff || in_valid;
         skid_v_ff <= skid_v_ff && in_valid;
      end else if (in_valid) begin
         skid_v_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (!out_v_ff || pop) begin
         out_ff <= skid_v_ff ? skid_ff : in_data;
         if (skid_v_ff) skid_ff <= in_data;
      end else if (in_valid && !skid_v_ff) begin
         skid_ff <= in_data;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.kind = out_ff.kind;
   assign rsp.field_id = out_ff.field_id;
   assign rsp.field_value = out_ff.field_value;
   assign rsp.object_index = out_ff.object_index;
   assign rsp.block_index = out_ff.block_index;
   assign rsp.status = out_ff.status;
   assign rsp.bits_consumed = out_ff.bits_consumed;
   assign rsp.padding_bits = out_ff.padding_bits;
   assign rsp.last = out_ff.last;
endmodule

/* hdl/object_metadata_element_parser_unit.sv */
// channel   | dir | accepted when       | carries
// req_ch    | in  | valid && ready      | op, body_bit, map_object, map_flag
// rsp_ch    | out | valid && ready      | one field record or the final status
// csr_ch    | in  | valid (ready high)  | index, data (0 object_count, 1 presence order)
//
// One request per cycle while ready is high; a record is registered once its last bit is taken.
// The parse state, output register and skid entry are the stages; the bed map read
// is registered and follows the next object index, so it is ready for the next bit.
// Synchronous active-high reset: object_count 1, presence order 0, parse at its start.
// req_ch.ready drops only while both the output register and skid entry are full.
`timescale 1ns / 1ps

module object_metadata_element_parser_unit #(
   parameter int MAX_OBJECTS   = 159,
   parameter int MAX_BLOCKS    = 8,
   parameter int MAX_BODY_BITS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   omep_req_if.sink    req_ch,
   omep_rsp_if.source  rsp_ch,
   omep_csr_if.sink    csr_ch
);
   logic                 req_acc;
   logic                 bed_flag;
   logic [7:0]           bed_rd_addr;
   omep_pkg::bed_wr_type bed_wr;
   logic                 res_valid;
   omep_pkg::rsp_type    res;
   logic                 buf_ready;

   // handshakes
   assign req_ch.ready = buf_ready;
   assign req_acc = req_ch.valid && buf_ready;
   assign csr_ch.ready = 1'b1;

   omep_bed_map #(
      .MAX_OBJECTS(MAX_OBJECTS)
   ) u_bed_map (
      .clock  (clock),
      .wr     (bed_wr),
      .rd_addr(bed_rd_addr),
      .rd_flag(bed_flag)
   );

   omep_parser #(
      .MAX_OBJECTS  (MAX_OBJECTS),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .MAX_BODY_BITS(MAX_BODY_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_acc    (req_acc),
      .op         (req_ch.op),
      .body_bit   (req_ch.body_bit),
      .map_object (req_ch.map_object),
      .map_flag   (req_ch.map_flag),
      .csr_we     (csr_ch.valid),
      .csr_index  (csr_ch.index),
      .csr_data   (csr_ch.data),
      .bed_flag   (bed_flag),
      .bed_wr     (bed_wr),
      .bed_rd_addr(bed_rd_addr),
      .res_valid  (res_valid),
      .res        (res)
   );

   omep_out_buf u_out_buf (
      .clock   (clock),
      .reset   (reset),
      .in_valid(res_valid),
      .in_data (res),
      .in_ready(buf_ready),
      .rsp     (rsp_ch)
   );
endmodule
